FILE: sv/hsv2rgb_pkg.sv
package hsv2rgb_pkg;

   // field widths
   localparam int unsigned HUE_WIDTH    = 9;
   localparam int unsigned LEVEL_WIDTH  = 8;
   localparam int unsigned OFFSET_WIDTH = 6;
   localparam int unsigned PROD_WIDTH   = LEVEL_WIDTH + OFFSET_WIDTH;
   localparam int unsigned RECIP_WIDTH  = 15;

   // hue geometry
   localparam logic [HUE_WIDTH-1:0]    HUE_FULL   = 9'd360;
   localparam logic [HUE_WIDTH-1:0]    SECTOR_DEG = 9'd60;
   localparam logic [OFFSET_WIDTH-1:0] SECTOR_SPAN = 6'd60;

   // level arithmetic
   localparam logic [LEVEL_WIDTH-1:0] LEVEL_MAX   = 8'd255;
   // x / 60 == (x * 17477) >> 20 for every x below 2^14
   localparam logic [RECIP_WIDTH-1:0] RECIP_60    = 15'd17477;
   localparam int unsigned            RECIP_SHIFT = 20;

   // default depth of the queue between front and back
   localparam int unsigned QUEUE_DEPTH_DEF = 4;

   // 60-degree hue sectors
   typedef enum logic [2:0] {
      SEC_RED     = 3'd0,
      SEC_YELLOW  = 3'd1,
      SEC_GREEN   = 3'd2,
      SEC_CYAN    = 3'd3,
      SEC_BLUE    = 3'd4,
      SEC_MAGENTA = 3'd5
   } sector_type;

   // classified request held in the queue
   typedef struct packed {
      logic                    grey;
      sector_type              sector;
      logic [OFFSET_WIDTH-1:0] offset;
      logic [LEVEL_WIDTH-1:0]  saturation;
      logic [LEVEL_WIDTH-1:0]  brightness;
   } item_type;

   // first hue angle of a sector
   function automatic logic [HUE_WIDTH-1:0] sector_start(input sector_type sec);
      logic [HUE_WIDTH-1:0] start;
      case (sec)
         SEC_RED:     start = 9'd0;
         SEC_YELLOW:  start = 9'd60;
         SEC_GREEN:   start = 9'd120;
         SEC_CYAN:    start = 9'd180;
         SEC_BLUE:    start = 9'd240;
         SEC_MAGENTA: start = 9'd300;
         default:     start = 9'd0;
      endcase
      return start;
   endfunction

endpackage

FILE: sv/hsv2rgb_front.sv
module hsv2rgb_front (
   input  logic [hsv2rgb_pkg::HUE_WIDTH-1:0]   hue_deg,
   input  logic [hsv2rgb_pkg::LEVEL_WIDTH-1:0] saturation,
   input  logic [hsv2rgb_pkg::LEVEL_WIDTH-1:0] brightness,
   output hsv2rgb_pkg::item_type               item
);
   import hsv2rgb_pkg::*;

   logic [HUE_WIDTH-1:0]    hue_wrap;
   logic [HUE_WIDTH-1:0]    pos_full;
   logic [OFFSET_WIDTH-1:0] pos;
   sector_type              sector;

   // fold hue into 0..359, 360 and above wrap round
   assign hue_wrap = (hue_deg >= HUE_FULL) ? (hue_deg - HUE_FULL) : hue_deg;

   // sector by compare chain
   always_comb begin
      if (hue_wrap < SECTOR_DEG) begin
         sector = SEC_RED;
      end else if (hue_wrap < 9'(2 * SECTOR_DEG)) begin
         sector = SEC_YELLOW;
      end else if (hue_wrap < 9'(3 * SECTOR_DEG)) begin
         sector = SEC_GREEN;
      end else if (hue_wrap < 9'(4 * SECTOR_DEG)) begin
         sector = SEC_CYAN;
      end else if (hue_wrap < 9'(5 * SECTOR_DEG)) begin
         sector = SEC_BLUE;
      end else begin
         sector = SEC_MAGENTA;
      end
   end

   // position inside the sector
   assign pos_full = hue_wrap - sector_start(sector);
   assign pos      = pos_full[OFFSET_WIDTH-1:0];

   // ramp offset: rising sectors use the position, falling ones its complement
   always_comb begin
      item.grey       = (saturation == '0);
      item.sector     = sector;
      item.saturation = saturation;
      item.brightness = brightness;
      case (sector)
         SEC_YELLOW, SEC_CYAN, SEC_MAGENTA: item.offset = SECTOR_SPAN - pos;
         default:                           item.offset = pos;
      endcase
   end

endmodule

FILE: sv/hsv2rgb_queue.sv
module hsv2rgb_queue #(
   parameter int unsigned DEPTH = hsv2rgb_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  hsv2rgb_pkg::item_type push_item,
   output logic                  full,
   input  logic                  pop,
   output hsv2rgb_pkg::item_type pop_item,
   output logic                  empty
);
   import hsv2rgb_pkg::*;

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   item_type           entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff,  count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_item = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue fill count above depth");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue popped while empty");

endmodule

FILE: sv/hsv2rgb_back.sv
module hsv2rgb_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                q_empty,
   input  hsv2rgb_pkg::item_type               q_item,
   output logic                                q_pop,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output logic [hsv2rgb_pkg::LEVEL_WIDTH-1:0] rsp_red,
   output logic [hsv2rgb_pkg::LEVEL_WIDTH-1:0] rsp_green,
   output logic [hsv2rgb_pkg::LEVEL_WIDTH-1:0] rsp_blue
);
   import hsv2rgb_pkg::*;

   logic advance;

   // stage 1: floor level
   logic                       s1_valid_ff, s1_valid_in;
   logic                       s1_grey_ff;
   sector_type                 s1_sector_ff;
   logic [OFFSET_WIDTH-1:0]    s1_offset_ff;
   logic [LEVEL_WIDTH-1:0]     s1_bright_ff;
   logic [LEVEL_WIDTH-1:0]     s1_base_ff, s1_base_in;
   logic [2*LEVEL_WIDTH-1:0]   base_prod;

   // stage 2: ramp numerator
   logic                       s2_valid_ff;
   logic                       s2_grey_ff;
   sector_type                 s2_sector_ff;
   logic [LEVEL_WIDTH-1:0]     s2_bright_ff;
   logic [LEVEL_WIDTH-1:0]     s2_base_ff;
   logic [PROD_WIDTH-1:0]      s2_prod_ff, s2_prod_in;
   logic [LEVEL_WIDTH-1:0]     span;

   // stage 3: divide by sector width, select channels
   logic [PROD_WIDTH+RECIP_WIDTH-1:0] recip_prod;
   logic [LEVEL_WIDTH:0]              ramp_sum;
   logic [LEVEL_WIDTH-1:0]            ramp;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_WIDTH-1:0]            rsp_red_ff, rsp_red_in;
   logic [LEVEL_WIDTH-1:0]            rsp_green_ff, rsp_green_in;
   logic [LEVEL_WIDTH-1:0]            rsp_blue_ff, rsp_blue_in;

   // whole pipeline moves when the output register is free
   assign advance     = !rsp_valid_ff || !rsp_stall;
   assign q_pop       = advance && !q_empty;
   assign s1_valid_in = q_pop;

   // base = ((255 - sat) * val) >> 8
   assign base_prod  = (LEVEL_MAX - q_item.saturation) * q_item.brightness;
   assign s1_base_in = base_prod[2*LEVEL_WIDTH-1:LEVEL_WIDTH];

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_grey_ff   <= q_item.grey;
         s1_sector_ff <= q_item.sector;
         s1_offset_ff <= q_item.offset;
         s1_bright_ff <= q_item.brightness;
         s1_base_ff   <= s1_base_in;
      end
   end

   // (val - base) * offset
   assign span       = s1_bright_ff - s1_base_ff;
   assign s2_prod_in = span * s1_offset_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_grey_ff   <= s1_grey_ff;
         s2_sector_ff <= s1_sector_ff;
         s2_bright_ff <= s1_bright_ff;
         s2_base_ff   <= s1_base_ff;
         s2_prod_ff   <= s2_prod_in;
      end
   end

   // truncating divide by 60 through the reciprocal, then add the floor
   assign recip_prod = s2_prod_ff * RECIP_60;
   assign ramp_sum   = {1'b0, recip_prod[RECIP_SHIFT +: LEVEL_WIDTH]} + {1'b0, s2_base_ff};
   assign ramp       = ramp_sum[LEVEL_WIDTH-1:0];

   // channel selection per sector
   always_comb begin
      rsp_valid_in = advance ? s2_valid_ff : rsp_valid_ff;
      if (s2_grey_ff) begin
         rsp_red_in   = s2_bright_ff;
         rsp_green_in = s2_bright_ff;
         rsp_blue_in  = s2_bright_ff;
      end else begin
         case (s2_sector_ff)
            SEC_RED: begin
               rsp_red_in = s2_bright_ff; rsp_green_in = ramp; rsp_blue_in = s2_base_ff;
            end
            SEC_YELLOW: begin
               rsp_red_in = ramp; rsp_green_in = s2_bright_ff; rsp_blue_in = s2_base_ff;
            end
            SEC_GREEN: begin
               rsp_red_in = s2_base_ff; rsp_green_in = s2_bright_ff; rsp_blue_in = ramp;
            end
            SEC_CYAN: begin
               rsp_red_in = s2_base_ff; rsp_green_in = ramp; rsp_blue_in = s2_bright_ff;
            end
            SEC_BLUE: begin
               rsp_red_in = ramp; rsp_green_in = s2_base_ff; rsp_blue_in = s2_bright_ff;
            end
            default: begin
               rsp_red_in = s2_bright_ff; rsp_green_in = s2_base_ff; rsp_blue_in = ramp;
            end
         endcase
      end
   end

   // output register payload
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_red_ff   <= rsp_red_in;
         rsp_green_ff <= rsp_green_in;
         rsp_blue_ff  <= rsp_blue_in;
      end
   end

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            s1_valid_ff <= s1_valid_in;
            s2_valid_ff <= s1_valid_ff;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_red   = rsp_red_ff;
   assign rsp_green = rsp_green_ff;
   assign rsp_blue  = rsp_blue_ff;

   a_base_below_val: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (s1_base_ff <= s1_bright_ff))
      else $error("floor level above brightness");

   a_stage_to_output: assert property (@(posedge clock) disable iff (reset)
      (advance && s2_valid_ff) |=> rsp_valid_ff)
      else $error("request lost between last stage and output");

endmodule

FILE: sv/hsv_to_rgb_integer_unit.sv
// HSV to 8-bit RGB converter. Takes a hue in whole degrees (360 and above
// wrap round, so 360 gives red), a saturation and a brightness, and returns
// red, green and blue levels; zero saturation gives grey at the brightness.
// One request per clock is sustained while rsp_stall is low. A request is
// classified by hue sector on entry and written to a queue of QUEUE_DEPTH
// entries; a three-stage back end (floor level multiply, ramp multiply,
// divide-by-60 reciprocal multiply with channel select into the output
// register) drains it. While rsp_stall is high and the output register holds
// a result, the back end holds and the queue absorbs up to QUEUE_DEPTH
// further requests before req_stall rises.
module hsv_to_rgb_integer_unit #(
   parameter int unsigned QUEUE_DEPTH = hsv2rgb_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [hsv2rgb_pkg::HUE_WIDTH-1:0]   req_hue_deg,
   input  logic [hsv2rgb_pkg::LEVEL_WIDTH-1:0] req_saturation,
   input  logic [hsv2rgb_pkg::LEVEL_WIDTH-1:0] req_brightness,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [hsv2rgb_pkg::LEVEL_WIDTH-1:0] rsp_red,
   output logic [hsv2rgb_pkg::LEVEL_WIDTH-1:0] rsp_green,
   output logic [hsv2rgb_pkg::LEVEL_WIDTH-1:0] rsp_blue
);
   import hsv2rgb_pkg::*;

   item_type front_item;
   item_type queue_item;
   logic     queue_full;
   logic     queue_empty;
   logic     queue_push;
   logic     queue_pop;

   // classify the incoming request
   hsv2rgb_front u_front (
      .hue_deg    (req_hue_deg),
      .saturation (req_saturation),
      .brightness (req_brightness),
      .item       (front_item)
   );

   assign req_stall  = queue_full;
   assign queue_push = req_valid && !queue_full;

   // decoupling queue
   hsv2rgb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_item (front_item),
      .full      (queue_full),
      .pop       (queue_pop),
      .pop_item  (queue_item),
      .empty     (queue_empty)
   );

   // arithmetic pipeline and output register
   hsv2rgb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (queue_empty),
      .q_item    (queue_item),
      .q_pop     (queue_pop),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_red   (rsp_red),
      .rsp_green (rsp_green),
      .rsp_blue  (rsp_blue)
   );

endmodule
